>>> hdl/min_tracking_stack_macros.svh
// Assertion helpers shared by the min_tracking_stack RTL.
`ifndef MIN_TRACKING_STACK_MACROS_SVH
`define MIN_TRACKING_STACK_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising edge outside reset.
`define MTS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define MTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MTS_ASSERT(lbl, clk, rst, prop, msg)
`define MTS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> hdl/mts_pkg.sv
`timescale 1ns / 1ps

package mts_pkg;

  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } mts_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POS,
    S_VAL
  } mts_state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic pos_step;
    logic val_step;
  } mts_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic reload_needed;
  } mts_sts_t;

endpackage

>>> hdl/min_tracking_stack.sv
`timescale 1ns / 1ps
// min_tracking_stack: LIFO of signed words that reports the running minimum.
// Command channel (cmd_valid / cmd_stall): action 0 pushes push_value,
// action 1 pops the top word. A word is taken when cmd_valid is high and
// cmd_stall is low.
// Response channel (rsp_valid / rsp_stall): one word per command with the
// minimum held, whether the stack is non-empty, the entry count and a status
// (ok, push refused because full, pop ignored because empty).
// A push, a refused command, or a pop that leaves the minimum in place
// answers in the cycle after it is taken; a new command can be taken every
// cycle unless a held response or a reload stalls it. A pop that removes
// the minimum but leaves entries answers after registered reads of the next
// minimum's position (position memory) and then value (value memory).
// Reset clears both counts at once; no clearing pass runs over the memories.
// While rsp_stall holds a response, cmd_stall rises and no command is taken
// until the response register frees up.
module min_tracking_stack
  import mts_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  localparam int CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  logic                          action,
  input  logic signed [VALUE_WIDTH-1:0] push_value,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic signed [VALUE_WIDTH-1:0] min_value,
  output logic                          min_valid,
  output logic [CW-1:0]                 entries_held,
  output logic [1:0]                    status
);

  mts_cmd_t cmd;
  mts_sts_t sts;

  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mts_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .action       (action),
    .push_value   (push_value),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .min_value    (min_value),
    .min_valid    (min_valid),
    .entries_held (entries_held),
    .status       (status)
  );

endmodule

>>> hdl/mts_ctrl.sv
`timescale 1ns / 1ps

`include "min_tracking_stack_macros.svh"

module mts_ctrl
  import mts_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  mts_sts_t sts,
  output mts_cmd_t cmd
);

  mts_state_t state;
  mts_state_t state_next;
  logic       accept;

  assign accept = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && sts.reload_needed) begin
          state_next = S_POS;
        end
      end
      S_POS:   state_next = S_VAL;
      S_VAL:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_stall    = 1'b1;
    cmd.accept   = 1'b0;
    cmd.pos_step = 1'b0;
    cmd.val_step = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd_stall  = !sts.out_free;
        cmd.accept = cmd_valid && sts.out_free;
      end
      S_POS:   cmd.pos_step = 1'b1;
      S_VAL:   cmd.val_step = 1'b1;
      default: cmd_stall = 1'b1;
    endcase
  end

  `MTS_ASSERT(a_pos_then_val, clk, rst, (state == S_POS) |=> (state == S_VAL), "reload skipped value read")

endmodule

>>> hdl/mts_datapath.sv
`timescale 1ns / 1ps

`include "min_tracking_stack_macros.svh"

module mts_datapath
  import mts_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  localparam int CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mts_cmd_t                      cmd,
  output mts_sts_t                      sts,
  input  logic                          action,
  input  logic signed [VALUE_WIDTH-1:0] push_value,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic signed [VALUE_WIDTH-1:0] min_value,
  output logic                          min_valid,
  output logic [CW-1:0]                 entries_held,
  output logic [1:0]                    status
);

  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [CW-1:0] TWO_C   = CW'(2);

  logic signed [VALUE_WIDTH-1:0] value_mem [STACK_DEPTH];
  logic [AW-1:0]                 pos_mem   [STACK_DEPTH];

  logic [CW-1:0]                 stack_count;
  logic [CW-1:0]                 min_count;
  logic signed [VALUE_WIDTH-1:0] min_val;
  logic [AW-1:0]                 min_pos;
  logic [AW-1:0]                 pos_rdata;
  logic signed [VALUE_WIDTH-1:0] val_rdata;

  logic          full;
  logic          empty;
  logic          take;
  logic          hit;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] count_dec;
  logic [CW-1:0] mcount_dec2;
  logic          do_push;
  logic          do_pop;
  logic          emit;

  logic signed [VALUE_WIDTH-1:0] res_min;
  logic                          res_valid;
  logic [CW-1:0]                 res_count;
  mts_status_t                   res_status;

  assign full        = (stack_count >= DEPTH_C);
  assign empty       = (stack_count == '0);
  assign count_inc   = stack_count + ONE_C;
  assign count_dec   = stack_count - ONE_C;
  assign mcount_dec2 = min_count - TWO_C;
  assign take        = (min_count == '0) || (push_value < min_val);
  assign hit         = (min_pos == count_dec[AW-1:0]);

  assign do_push = cmd.accept && (action == ACT_PUSH) && !full;
  assign do_pop  = cmd.accept && (action == ACT_POP) && !empty;

  assign sts.out_free      = !rsp_valid || !rsp_stall;
  assign sts.reload_needed = (action == ACT_POP) && !empty && hit && (min_count >= TWO_C);

  assign emit = (cmd.accept && !sts.reload_needed) || cmd.val_step;

  // result of the word just taken, or of a finished reload
  always_comb begin
    res_min    = min_val;
    res_valid  = 1'b1;
    res_count  = stack_count;
    res_status = ST_OK;
    if (cmd.val_step) begin
      res_min = val_rdata;
    end else if (action == ACT_PUSH) begin
      if (full) begin
        res_status = ST_FULL;
      end else begin
        res_count = count_inc;
        if (take) begin
          res_min = push_value;
        end
      end
    end else begin
      if (empty) begin
        res_status = ST_EMPTY;
        res_min    = '0;
        res_valid  = 1'b0;
      end else begin
        res_count = count_dec;
        if (count_dec == '0) begin
          res_min   = '0;
          res_valid = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      value_mem[stack_count[AW-1:0]] <= push_value;
      if (take) begin
        pos_mem[min_count[AW-1:0]] <= stack_count[AW-1:0];
      end
    end
    if (cmd.accept) begin
      pos_rdata <= pos_mem[mcount_dec2[AW-1:0]];
    end
    if (cmd.pos_step) begin
      val_rdata <= value_mem[pos_rdata];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count <= '0;
      min_count   <= '0;
    end else begin
      if (do_push) begin
        stack_count <= count_inc;
        if (take) begin
          min_count <= min_count + ONE_C;
        end
      end else if (do_pop) begin
        stack_count <= count_dec;
        if (hit) begin
          min_count <= min_count - ONE_C;
        end
      end
    end
  end

  // cached top of the minimum tracking stack
  always_ff @(posedge clk) begin
    if (do_push && take) begin
      min_val <= push_value;
      min_pos <= stack_count[AW-1:0];
    end
    if (cmd.pos_step) begin
      min_pos <= pos_rdata;
    end
    if (cmd.val_step) begin
      min_val <= val_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      min_value    <= res_min;
      min_valid    <= res_valid;
      entries_held <= res_count;
      status       <= res_status;
    end
  end

  `MTS_ASSERT(a_count_bound, clk, rst, stack_count <= DEPTH_C, "stack count past depth")
  `MTS_ASSERT(a_min_le_count, clk, rst, min_count <= stack_count, "min count above stack count")
  `MTS_ASSERT(a_min_tracks, clk, rst, (min_count == '0) == (stack_count == '0), "min stack out of step")

endmodule
